/* sv/sme_pkg.sv */
package sme_pkg;

  localparam int SET_CAP = 32;
  localparam int CNT_W   = $clog2(SET_CAP + 1);
  localparam int IDX_W   = (SET_CAP > 1) ? $clog2(SET_CAP) : 1;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;

  typedef enum logic [2:0] {
    K_ADD    = 3'd0,
    K_REMOVE = 3'd1,
    K_SEARCH = 3'd2,
    K_ISECT  = 3'd3,
    K_UNION  = 3'd4,
    K_DIFF12 = 3'd5,
    K_DIFF21 = 3'd6,
    K_UNUSED = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_SET   = 3'd4
  } status_t;

  localparam logic [1:0] SEL_FIRST  = 2'd1;
  localparam logic [1:0] SEL_SECOND = 2'd2;

  typedef enum logic [1:0] {
    CC_HOLD,
    CC_APPEND,
    CC_REMOVE,
    CC_ROTATE
  } chain_cmd_t;

  typedef struct packed {
    logic load;
    logic take_next;
    logic take_head;
  } cell_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] head;
  } chain_stat_t;

endpackage

/* sv/sme_cell.sv */
module sme_cell (
  input  logic                     clk,
  input  sme_pkg::cell_ctl_t       ctl,
  input  logic [sme_pkg::VAL_W-1:0] load_val,
  input  logic [sme_pkg::VAL_W-1:0] next_val,
  input  logic [sme_pkg::VAL_W-1:0] head_val,
  input  logic [sme_pkg::VAL_W-1:0] key,
  output logic [sme_pkg::VAL_W-1:0] val,
  output logic                     hit
);

  logic [sme_pkg::VAL_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= load_val;
    end else if (ctl.take_head) begin
      val_r <= head_val;
    end else if (ctl.take_next) begin
      val_r <= next_val;
    end
  end

  assign val = val_r;
  assign hit = (val_r == key);

endmodule

/* sv/sme_chain.sv */
module sme_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sme_pkg::chain_cmd_t       cmd,
  input  logic [sme_pkg::VAL_W-1:0] key,
  output sme_pkg::chain_stat_t      stat
);

  localparam int N = sme_pkg::SET_CAP;

  logic [sme_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [sme_pkg::VAL_W-1:0] vals [N];
  logic [N-1:0]              hits;
  logic [sme_pkg::IDX_W-1:0] pos_terms [N];
  logic [sme_pkg::IDX_W-1:0] pos;

  for (genvar i = 0; i < N; i++) begin : g_cell
    sme_pkg::cell_ctl_t        ctl;
    logic [sme_pkg::VAL_W-1:0] nv;
    logic                      raw_hit;

    if (i < N - 1) begin : g_mid
      assign nv = vals[i+1];
    end else begin : g_end
      assign nv = vals[i];
    end

    // remove: cells at and above the hit take their upper neighbor
    // rotate: cells below the top valid one shift down, the top one takes the head
    assign ctl.load      = (cmd == sme_pkg::CC_APPEND) &&
                           (count_r == sme_pkg::CNT_W'(i));
    assign ctl.take_next = ((cmd == sme_pkg::CC_REMOVE) &&
                            (sme_pkg::IDX_W'(i) >= pos)) ||
                           ((cmd == sme_pkg::CC_ROTATE) &&
                            (sme_pkg::CNT_W'(i + 1) < count_r));
    assign ctl.take_head = (cmd == sme_pkg::CC_ROTATE) &&
                           (sme_pkg::CNT_W'(i + 1) == count_r);

    sme_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_val (key),
      .next_val (nv),
      .head_val (vals[0]),
      .key      (key),
      .val      (vals[i]),
      .hit      (raw_hit)
    );

    assign hits[i]      = raw_hit && (sme_pkg::CNT_W'(i) < count_r);
    assign pos_terms[i] = sme_pkg::IDX_W'(i) & {sme_pkg::IDX_W{hits[i]}};
  end

  // sets hold no duplicates, so at most one hit and an or-merge gives its index
  always_comb begin
    pos = '0;
    for (int j = 0; j < N; j++) begin
      pos = pos | pos_terms[j];
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (cmd)
      sme_pkg::CC_APPEND: count_nxt = count_r + sme_pkg::CNT_W'(1);
      sme_pkg::CC_REMOVE: count_nxt = count_r - sme_pkg::CNT_W'(1);
      default:            count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.found = |hits;
  assign stat.pos   = pos;
  assign stat.count = count_r;
  assign stat.head  = vals[0];

endmodule

/* sv/two_set_membership_engine.sv */
// channel | direction | handshake              | payload
// in      | slave     | in_tvalid / in_tready  | tdata value, tuser kind + which_set
// out     | master    | out_tvalid / out_tready| tdata status/position/member,
//         |           |                        | tuser member_valid, tlast last
// add, remove, search: accepted while idle, result registered once the output is free.
// set operations: the source chain rotates one entry per cycle unless a stalled output holds
// the scan, while the other chain compares it against all entries at once.
// kind 7 is accepted and dropped with no result.
// reset clears both counts; stores stay unknown and need no clearing pass.
// a stalled output holds the scan once a second kept member is waiting.
module two_set_membership_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [4:0]  in_tuser,   // kind[2:0], which_set[4:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[2:0], position[7:3], member[39:8]
  output logic        out_tuser,  // member_valid
  output logic        out_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_SINGLE, S_SCAN, S_FLUSH} state_t;
  typedef enum logic [1:0] {KEEP_ALL, KEEP_HIT, KEEP_MISS} keep_t;

  state_t                    state_r, state_nxt;
  keep_t                     mode_r, mode_nxt;
  sme_pkg::kind_t            kind_r, kind_nxt;
  logic [1:0]                sel_r, sel_nxt;
  logic [sme_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                      src_sel_r, src_sel_nxt;   // 0 scans first, 1 scans second
  logic                      union_r, union_nxt;       // second phase still to come
  logic [sme_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  logic [sme_pkg::VAL_W-1:0] pend_r, pend_nxt;

  logic                      out_vld_r, out_vld_nxt;
  sme_pkg::status_t          out_st_r, out_st_nxt;
  logic [sme_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [sme_pkg::VAL_W-1:0] out_mem_r, out_mem_nxt;
  logic                      out_mv_r, out_mv_nxt;
  logic                      out_last_r, out_last_nxt;

  sme_pkg::chain_cmd_t       cmd_first, cmd_second;
  sme_pkg::chain_stat_t      first_stat, second_stat, tgt_stat;
  logic [sme_pkg::VAL_W-1:0] key_first, key_second;
  logic [sme_pkg::CNT_W-1:0] src_count;
  logic [sme_pkg::VAL_W-1:0] src_head;
  logic                      other_found, keep, out_free, in_fire;
  sme_pkg::chain_cmd_t       single_cmd;
  sme_pkg::kind_t            in_kind;

  assign in_kind   = sme_pkg::kind_t'(in_tuser[2:0]);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  assign src_count   = src_sel_r ? second_stat.count : first_stat.count;
  assign src_head    = src_sel_r ? second_stat.head  : first_stat.head;
  assign other_found = src_sel_r ? first_stat.found  : second_stat.found;
  assign keep = (mode_r == KEEP_ALL) ||
                ((mode_r == KEEP_HIT) && other_found) ||
                ((mode_r == KEEP_MISS) && !other_found);
  assign tgt_stat = (sel_r == sme_pkg::SEL_SECOND) ? second_stat : first_stat;

  assign key_first  = ((state_r == S_SCAN) && src_sel_r)  ? second_stat.head : value_r;
  assign key_second = ((state_r == S_SCAN) && !src_sel_r) ? first_stat.head  : value_r;

  sme_chain u_first (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd_first),
    .key  (key_first),
    .stat (first_stat)
  );

  sme_chain u_second (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd_second),
    .key  (key_second),
    .stat (second_stat)
  );

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    kind_nxt     = kind_r;
    sel_nxt      = sel_r;
    value_nxt    = value_r;
    src_sel_nxt  = src_sel_r;
    union_nxt    = union_r;
    idx_nxt      = idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_st_nxt   = out_st_r;
    out_pos_nxt  = out_pos_r;
    out_mem_nxt  = out_mem_r;
    out_mv_nxt   = out_mv_r;
    out_last_nxt = out_last_r;
    cmd_first    = sme_pkg::CC_HOLD;
    cmd_second   = sme_pkg::CC_HOLD;
    single_cmd   = sme_pkg::CC_HOLD;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt     = in_kind;
          sel_nxt      = in_tuser[4:3];
          value_nxt    = in_tdata;
          idx_nxt      = '0;
          pend_vld_nxt = 1'b0;
          union_nxt    = 1'b0;
          case (in_kind)
            sme_pkg::K_ADD, sme_pkg::K_REMOVE, sme_pkg::K_SEARCH: begin
              state_nxt = S_SINGLE;
            end
            sme_pkg::K_ISECT: begin
              state_nxt   = S_SCAN;
              src_sel_nxt = 1'b0;
              mode_nxt    = KEEP_HIT;
            end
            sme_pkg::K_UNION: begin
              state_nxt   = S_SCAN;
              src_sel_nxt = 1'b1;
              mode_nxt    = KEEP_ALL;
              union_nxt   = 1'b1;
            end
            sme_pkg::K_DIFF12: begin
              state_nxt   = S_SCAN;
              src_sel_nxt = 1'b0;
              mode_nxt    = KEEP_MISS;
            end
            sme_pkg::K_DIFF21: begin
              state_nxt   = S_SCAN;
              src_sel_nxt = 1'b1;
              mode_nxt    = KEEP_MISS;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_SINGLE: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_pos_nxt  = '0;
          out_mem_nxt  = '0;
          out_mv_nxt   = 1'b0;
          out_last_nxt = 1'b1;
          out_st_nxt   = sme_pkg::ST_OK;
          state_nxt    = S_IDLE;
          if ((sel_r != sme_pkg::SEL_FIRST) && (sel_r != sme_pkg::SEL_SECOND)) begin
            out_st_nxt = sme_pkg::ST_BAD_SET;
          end else begin
            case (kind_r)
              sme_pkg::K_ADD: begin
                if (tgt_stat.found) begin
                  out_st_nxt = sme_pkg::ST_PRESENT;
                end else if (tgt_stat.count >= sme_pkg::CNT_W'(sme_pkg::SET_CAP)) begin
                  out_st_nxt = sme_pkg::ST_FULL;
                end else begin
                  single_cmd = sme_pkg::CC_APPEND;
                end
              end
              sme_pkg::K_REMOVE: begin
                if (!tgt_stat.found) begin
                  out_st_nxt = sme_pkg::ST_NOT_FOUND;
                end else begin
                  single_cmd = sme_pkg::CC_REMOVE;
                end
              end
              default: begin
                if (!tgt_stat.found) begin
                  out_st_nxt = sme_pkg::ST_NOT_FOUND;
                end else begin
                  out_pos_nxt = sme_pkg::POS_W'(tgt_stat.pos);
                end
              end
            endcase
            if (sel_r == sme_pkg::SEL_SECOND) begin
              cmd_second = single_cmd;
            end else begin
              cmd_first = single_cmd;
            end
          end
        end
      end

      S_SCAN: begin
        if (idx_r == src_count) begin
          if (union_r) begin
            union_nxt   = 1'b0;
            src_sel_nxt = 1'b0;
            mode_nxt    = KEEP_MISS;
            idx_nxt     = '0;
          end else begin
            state_nxt = S_FLUSH;
          end
        end else if (!(keep && pend_vld_r && !out_free)) begin
          idx_nxt = idx_r + sme_pkg::CNT_W'(1);
          if (src_sel_r) begin
            cmd_second = sme_pkg::CC_ROTATE;
          end else begin
            cmd_first = sme_pkg::CC_ROTATE;
          end
          if (keep) begin
            // the held member is not the final one, so it leaves without last
            if (pend_vld_r) begin
              out_vld_nxt  = 1'b1;
              out_st_nxt   = sme_pkg::ST_OK;
              out_pos_nxt  = '0;
              out_mem_nxt  = pend_r;
              out_mv_nxt   = 1'b1;
              out_last_nxt = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_nxt     = src_head;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_st_nxt   = sme_pkg::ST_OK;
          out_pos_nxt  = '0;
          out_mem_nxt  = pend_vld_r ? pend_r : '0;
          out_mv_nxt   = pend_vld_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      union_r    <= 1'b0;
      idx_r      <= '0;
      mode_r     <= KEEP_ALL;
      src_sel_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      union_r    <= union_nxt;
      idx_r      <= idx_nxt;
      mode_r     <= mode_nxt;
      src_sel_r  <= src_sel_nxt;
    end
    kind_r     <= kind_nxt;
    sel_r      <= sel_nxt;
    value_r    <= value_nxt;
    pend_r     <= pend_nxt;
    out_st_r   <= out_st_nxt;
    out_pos_r  <= out_pos_nxt;
    out_mem_r  <= out_mem_nxt;
    out_mv_r   <= out_mv_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_mem_r, out_pos_r, out_st_r};
  assign out_tuser  = out_mv_r;
  assign out_tlast  = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("member still held while idle");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= src_count))
    else $error("scan index ran past source count");

  a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd_first == sme_pkg::CC_APPEND) ||
     (cmd_second == sme_pkg::CC_APPEND)) |->
    (tgt_stat.count < sme_pkg::CNT_W'(sme_pkg::SET_CAP)))
    else $error("append into a full set");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (first_stat.count <= sme_pkg::CNT_W'(sme_pkg::SET_CAP)) &&
    (second_stat.count <= sme_pkg::CNT_W'(sme_pkg::SET_CAP)))
    else $error("set count above capacity");

endmodule

/* bench/sme_checker.sv */
module sme_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [4:0]  in_tuser,   // kind[2:0], which_set[4:3]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // status[2:0], position[7:3], member[39:8]
  input  logic        out_tuser,  // member_valid
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          answers_owed
);

  typedef struct {
    sme_pkg::status_t          status;
    logic [sme_pkg::POS_W-1:0] position;
    logic [sme_pkg::VAL_W-1:0] member;
    logic                      member_valid;
    logic                      last;
  } answer_t;

  // index 0 holds the first set, index 1 the second
  logic [sme_pkg::VAL_W-1:0] members [2][sme_pkg::SET_CAP];
  int                        fill    [2];
  answer_t                   owed_q  [$];
  int                        errs = 0;

  function automatic int locate(input int s, input logic [sme_pkg::VAL_W-1:0] v);
    int i;
    for (i = 0; i < fill[s]; i++)
      if (members[s][i] == v) return i;
    return -1;
  endfunction

  task automatic owe(input sme_pkg::status_t st, input int pos,
                     input logic [sme_pkg::VAL_W-1:0] m, input logic mv, input logic lst);
    answer_t a;
    a.status       = st;
    a.position     = pos[sme_pkg::POS_W-1:0];
    a.member       = m;
    a.member_valid = mv;
    a.last         = lst;
    owed_q.push_back(a);
  endtask

  // members of src whose presence in the other set equals keep_present
  task automatic collect(input int src, input logic keep_present);
    int  i;
    logic present;
    for (i = 0; i < fill[src]; i++) begin
      present = (locate(1 - src, members[src][i]) >= 0);
      if (present == keep_present) owe(sme_pkg::ST_OK, 0, members[src][i], 1'b1, 1'b0);
    end
  endtask

  task automatic apply_request(input sme_pkg::kind_t k, input logic [1:0] sel,
                               input logic [sme_pkg::VAL_W-1:0] v);
    int      s;
    int      pos;
    int      i;
    int      start;
    answer_t tail;
    start = owed_q.size();
    if (k == sme_pkg::K_ADD || k == sme_pkg::K_REMOVE || k == sme_pkg::K_SEARCH) begin
      if (sel != sme_pkg::SEL_FIRST && sel != sme_pkg::SEL_SECOND) begin
        owe(sme_pkg::ST_BAD_SET, 0, '0, 1'b0, 1'b1);
        return;
      end
      s   = (sel == sme_pkg::SEL_FIRST) ? 0 : 1;
      pos = locate(s, v);
      case (k)
        sme_pkg::K_ADD: begin
          if (pos >= 0) owe(sme_pkg::ST_PRESENT, 0, '0, 1'b0, 1'b1);
          else if (fill[s] >= sme_pkg::SET_CAP) owe(sme_pkg::ST_FULL, 0, '0, 1'b0, 1'b1);
          else begin
            members[s][fill[s]] = v;
            fill[s]++;
            owe(sme_pkg::ST_OK, 0, '0, 1'b0, 1'b1);
          end
        end
        sme_pkg::K_REMOVE: begin
          if (pos < 0) owe(sme_pkg::ST_NOT_FOUND, 0, '0, 1'b0, 1'b1);
          else begin
            for (i = pos; i + 1 < fill[s]; i++) members[s][i] = members[s][i + 1];
            fill[s]--;
            owe(sme_pkg::ST_OK, 0, '0, 1'b0, 1'b1);
          end
        end
        default: begin
          if (pos < 0) owe(sme_pkg::ST_NOT_FOUND, 0, '0, 1'b0, 1'b1);
          else owe(sme_pkg::ST_OK, pos, '0, 1'b0, 1'b1);
        end
      endcase
      return;
    end
    case (k)
      sme_pkg::K_ISECT: collect(0, 1'b1);
      sme_pkg::K_UNION: begin
        for (i = 0; i < fill[1]; i++) owe(sme_pkg::ST_OK, 0, members[1][i], 1'b1, 1'b0);
        collect(0, 1'b0);
      end
      sme_pkg::K_DIFF12: collect(0, 1'b0);
      sme_pkg::K_DIFF21: collect(1, 1'b0);
      default: return;
    endcase
    if (owed_q.size() == start) owe(sme_pkg::ST_OK, 0, '0, 1'b0, 1'b1);
    else begin
      tail      = owed_q.pop_back();
      tail.last = 1'b1;
      owed_q.push_back(tail);
    end
  endtask

  task automatic check_answer();
    answer_t want;
    if (owed_q.size() == 0) begin
      $error("result with nothing owed: status %0d member %0d",
             out_tdata[2:0], $signed(out_tdata[39:8]));
      errs++;
      return;
    end
    want = owed_q.pop_front();
    if (out_tdata[2:0] !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_tdata[2:0]);
      errs++;
    end
    if (out_tdata[7:3] !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, out_tdata[7:3]);
      errs++;
    end
    if (out_tdata[39:8] !== want.member) begin
      $error("member: expected %0d, got %0d", $signed(want.member),
             $signed(out_tdata[39:8]));
      errs++;
    end
    if (out_tuser !== want.member_valid) begin
      $error("member_valid: expected %0b, got %0b", want.member_valid, out_tuser);
      errs++;
    end
    if (out_tlast !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, out_tlast);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill[0] = 0;
      fill[1] = 0;
      owed_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        apply_request(sme_pkg::kind_t'(in_tuser[2:0]), in_tuser[4:3], in_tdata);
      if (out_tvalid && out_tready) check_answer();
    end
    mismatch_count <= errs;
    answers_owed   <= owed_q.size();
  end

endmodule

/* bench/tb_two_set_membership_engine.sv */
module tb_two_set_membership_engine;

  localparam int         IDLE_LIMIT   = 5000;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         DRAIN_CYCLES = 100;
  localparam int         POOL_SIZE    = 48;
  localparam logic [1:0] SEL_NONE     = 2'd0;
  localparam logic [1:0] SEL_SPARE    = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // value[31:0]
  logic [4:0]  in_tuser   = '0;   // kind[2:0], which_set[4:3]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // status[2:0], position[7:3], member[39:8]
  logic        out_tuser;         // member_valid
  logic        out_tlast;

  int          mismatch_count;
  int          answers_owed;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_ask       = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;
  logic [31:0] pool [POOL_SIZE];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  two_set_membership_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sme_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .answers_owed   (answers_owed)
  );

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_ask != hold_seen) begin
      hold_seen  <= hold_ask;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $error("no transaction for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input sme_pkg::kind_t k, input logic [1:0] s,
                           input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {s, k};
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_request(input logic [1:0] fav);
    int             r;
    sme_pkg::kind_t k;
    logic [1:0]     s;
    logic [31:0]    v;
    r = $urandom_range(99);
    if (r < 45)      k = sme_pkg::K_ADD;
    else if (r < 58) k = sme_pkg::K_REMOVE;
    else if (r < 72) k = sme_pkg::K_SEARCH;
    else if (r < 78) k = sme_pkg::K_ISECT;
    else if (r < 84) k = sme_pkg::K_UNION;
    else if (r < 90) k = sme_pkg::K_DIFF12;
    else if (r < 96) k = sme_pkg::K_DIFF21;
    else             k = sme_pkg::K_UNUSED;
    r = $urandom_range(99);
    if (r < 4)       s = SEL_NONE;
    else if (r < 8)  s = SEL_SPARE;
    else if (r < 68) s = fav;
    else             s = (fav == sme_pkg::SEL_FIRST) ? sme_pkg::SEL_SECOND : sme_pkg::SEL_FIRST;
    v = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_SIZE - 1)] : $urandom();
    send_item(k, s, v);
  endtask

  initial begin
    int         ph;
    int         n;
    logic [1:0] fav;
    for (n = 0; n < POOL_SIZE; n++) pool[n] = $urandom();
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty sets: searches miss, set operations give the empty answer
    send_item(sme_pkg::K_SEARCH, sme_pkg::SEL_FIRST, 32'd7);
    send_item(sme_pkg::K_ISECT,  SEL_NONE,  32'd0);
    send_item(sme_pkg::K_UNION,  SEL_NONE,  32'd0);
    send_item(sme_pkg::K_DIFF12, SEL_NONE,  32'd0);
    send_item(sme_pkg::K_DIFF21, SEL_NONE,  32'd0);
    // invalid set numbers
    send_item(sme_pkg::K_ADD,    SEL_NONE,  32'd1);
    send_item(sme_pkg::K_REMOVE, SEL_SPARE, 32'd1);
    send_item(sme_pkg::K_SEARCH, SEL_NONE,  32'd1);
    // extremes, then a duplicate add
    send_item(sme_pkg::K_ADD,    sme_pkg::SEL_FIRST,  32'h8000_0000);
    send_item(sme_pkg::K_ADD,    sme_pkg::SEL_FIRST,  32'h7fff_ffff);
    send_item(sme_pkg::K_ADD,    sme_pkg::SEL_FIRST,  32'h0000_0000);
    send_item(sme_pkg::K_ADD,    sme_pkg::SEL_FIRST,  32'hffff_ffff);
    send_item(sme_pkg::K_ADD,    sme_pkg::SEL_FIRST,  32'h0000_0000);
    send_item(sme_pkg::K_ADD,    sme_pkg::SEL_SECOND, 32'h7fff_ffff);
    send_item(sme_pkg::K_ADD,    sme_pkg::SEL_SECOND, 32'd5);
    send_item(sme_pkg::K_SEARCH, sme_pkg::SEL_FIRST,  32'h7fff_ffff);
    send_item(sme_pkg::K_ISECT,  sme_pkg::SEL_FIRST,  32'd0);
    send_item(sme_pkg::K_UNION,  sme_pkg::SEL_FIRST,  32'd0);
    send_item(sme_pkg::K_DIFF12, sme_pkg::SEL_FIRST,  32'd0);
    send_item(sme_pkg::K_DIFF21, sme_pkg::SEL_FIRST,  32'd0);
    // removal of the head shifts the rest down
    send_item(sme_pkg::K_REMOVE, sme_pkg::SEL_FIRST,  32'h8000_0000);
    send_item(sme_pkg::K_SEARCH, sme_pkg::SEL_FIRST,  32'hffff_ffff);
    send_item(sme_pkg::K_REMOVE, sme_pkg::SEL_SECOND, 32'd12345);
    send_item(sme_pkg::K_UNUSED, SEL_SPARE,           32'hffff_ffff);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 73; end
        default: begin send_idle_pct = 23; recv_stall_pct <= 23; end
      endcase
      fav = (ph % 2 == 0) ? sme_pkg::SEL_FIRST : sme_pkg::SEL_SECOND;
      // add burst pushes the favored set toward capacity
      for (n = 0; n < 24; n++)
        send_item(sme_pkg::K_ADD, fav, pool[$urandom_range(POOL_SIZE - 1)]);
      for (n = 0; n < 92; n++) begin
        if (ph == 0 && n == 10) hold_ask <= hold_ask + 1;
        random_request(fav);
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (answers_owed != 0) $error("%0d results never arrived", answers_owed);
    if (mismatch_count == 0 && answers_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
